@@ design/kwsc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_pkg
// Shared types, codes and helpers for the keyword substitution cipher unit.
// ----------------------------------------------------------------------------
package kwsc_pkg;

  localparam int ALPHA_SIZE = 26;
  localparam int LW         = $clog2(ALPHA_SIZE);

  typedef logic [LW-1:0] letter_t;
  typedef logic [LW:0]   count_t;

  localparam letter_t LAST_LETTER = letter_t'(ALPHA_SIZE - 1);
  localparam count_t  FULL_COUNT  = count_t'(ALPHA_SIZE);

  // ASCII codes
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CASE_GAP = 8'd32;
  localparam logic [7:0] UC_A     = 8'h41;
  localparam logic [7:0] UC_Z     = 8'h5A;
  localparam logic [7:0] LC_A     = 8'd97;
  localparam logic [7:0] LC_Z     = 8'h7A;
  localparam logic [7:0] CH_NUL   = 8'd0;

  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_END = 2'd1,
    OP_ENC = 2'd2,
    OP_DEC = 2'd3
  } op_t;

  typedef struct packed {
    logic    is_letter;
    letter_t idx;
  } fold_t;

  // Requests from the sequencer to the table.
  typedef struct packed {
    logic    clear;
    logic    append;
    letter_t letter;
    logic    set_complete;
    logic    rd;
    letter_t rd_addr;
  } tbl_cmd_t;

  // Table status seen by the sequencer.
  typedef struct packed {
    logic [ALPHA_SIZE-1:0] used;
    count_t                fill_count;
    logic                  complete;
  } tbl_stat_t;

  function automatic fold_t letter_fold(input logic [7:0] c);
    logic [7:0] f;
    fold_t      r;
    f = c;
    if (c inside {[UC_A:UC_Z]}) begin
      f = c + CASE_GAP;
    end
    r.is_letter = (f inside {[LC_A:LC_Z]});
    r.idx       = letter_t'(f - LC_A);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/kwsc_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kwsc_table
// Cipher alphabet store: forward and inverse tables, used-letter mask and
// fill count, with one append unit shared by key words and the key-end fill.
// ----------------------------------------------------------------------------
module kwsc_table (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kwsc_pkg::tbl_cmd_t  cmd,
  output kwsc_pkg::tbl_stat_t      stat,
  output kwsc_pkg::letter_t        fwd_q,
  output kwsc_pkg::letter_t        inv_q
);
  import kwsc_pkg::*;

  letter_t fwd_mem [ALPHA_SIZE];
  letter_t inv_mem [ALPHA_SIZE];

  logic [ALPHA_SIZE-1:0] used;
  logic [ALPHA_SIZE-1:0] used_next;
  count_t                fill_count;
  count_t                fill_count_next;
  logic                  complete;
  logic                  complete_next;
  logic [ALPHA_SIZE-1:0] used_eff;
  count_t                count_eff;
  logic                  do_append;

  // A clear in the same cycle as an append acts first.
  always_comb begin
    used_eff  = cmd.clear ? '0 : used;
    count_eff = cmd.clear ? '0 : fill_count;
    do_append = cmd.append && !used_eff[cmd.letter] && (count_eff < FULL_COUNT);

    used_next       = used_eff;
    fill_count_next = count_eff;
    if (do_append) begin
      used_next[cmd.letter] = 1'b1;
      fill_count_next       = count_eff + count_t'(1);
    end

    complete_next = complete;
    if (cmd.clear) begin
      complete_next = 1'b0;
    end else if (cmd.set_complete) begin
      complete_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      fill_count <= '0;
      complete   <= 1'b0;
    end else begin
      used       <= used_next;
      fill_count <= fill_count_next;
      complete   <= complete_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      fwd_mem[count_eff[LW-1:0]] <= cmd.letter;
      inv_mem[cmd.letter]        <= count_eff[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      fwd_q <= fwd_mem[cmd.rd_addr];
      inv_q <= inv_mem[cmd.rd_addr];
    end
  end

  assign stat.used       = used;
  assign stat.fill_count = fill_count;
  assign stat.complete   = complete;

endmodule
`default_nettype wire

@@ design/keyword_substitution_cipher_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_substitution_cipher_unit
// Keyword monoalphabetic substitution: builds the cipher alphabet from key
// words and encrypts or decrypts one character per word.
//
//  channel | signals                      | dir | word contents
//  in      | in_valid, in_stall           | in  | operation, char_in
//  out     | out_valid, out_stall         | out | char_out
//
// Key character: one append through the shared table unit.
// Key end: the append unit walks all 26 letters in order.
// Encrypt/decrypt: registered table read, then result load;
//   bytes that are neither letters nor space give no word.
// Reset clears the used mask, fill count and complete flag at once.
// A stalled output word holds the lookup stage until it is taken.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [7:0] char_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      char_out
);
  import kwsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_FILL = 3'b010,
    S_LOOK = 3'b100
  } state_t;

  state_t    state;
  state_t    state_next;
  letter_t   fill_j;
  letter_t   fill_j_next;
  logic      look_enc;
  logic      look_space;
  letter_t   look_idx;
  tbl_cmd_t  cmd;
  tbl_stat_t stat;
  letter_t   fwd_q;
  letter_t   inv_q;
  fold_t     fold;
  op_t       op;
  logic      accept;
  logic      out_free;
  logic [7:0] result;

  kwsc_table u_table (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .stat  (stat),
    .fwd_q (fwd_q),
    .inv_q (inv_q)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(operation);
  assign fold     = letter_fold(char_in);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    fill_j_next = fill_j;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_KEY: begin
              cmd.clear  = stat.complete;
              cmd.append = fold.is_letter;
              cmd.letter = fold.idx;
            end
            OP_END: begin
              fill_j_next = '0;
              state_next  = S_FILL;
            end
            default: begin
              cmd.rd      = fold.is_letter;
              cmd.rd_addr = fold.idx;
              if (fold.is_letter || char_in == CH_SPACE) begin
                state_next = S_LOOK;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        cmd.append  = 1'b1;
        cmd.letter  = fill_j;
        fill_j_next = fill_j + letter_t'(1);
        if (fill_j == LAST_LETTER) begin
          cmd.set_complete = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (look_space) begin
      result = CH_SPACE;
    end else if (look_enc) begin
      result = (count_t'(look_idx) < stat.fill_count) ? (LC_A + 8'(fwd_q)) : CH_NUL;
    end else begin
      result = stat.used[look_idx] ? (LC_A + 8'(inv_q)) : LC_A;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOOK && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_j <= fill_j_next;
    if (accept) begin
      look_enc   <= (op == OP_ENC);
      look_space <= (char_in == CH_SPACE);
      look_idx   <= fold.idx;
    end
    if (state == S_LOOK && out_free) begin
      char_out <= result;
    end
  end

  // The used mask and fill count track each other.
  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    $countones(stat.used) == int'(stat.fill_count))
    else $error("fill count differs from used-letter mask");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.fill_count <= FULL_COUNT)
    else $error("fill count beyond alphabet size");

  a_fill_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && fill_j == LAST_LETTER) |=>
      (stat.complete && stat.fill_count == FULL_COUNT && stat.used == '1))
    else $error("key-end fill left the table incomplete");

  a_word_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_LOOK))
    else $error("output word raised outside lookup");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL || state == S_LOOK) |-> in_stall)
    else $error("input taken while busy");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for keyword_substitution_cipher_unit. A shadow copy of
// the cipher table tracks every accepted word, and each output word is
// compared with the oldest predicted character. Directed tests cover the
// blank table, partial keys, key end and a fresh key. Random key and
// lookup sessions follow, with bursty input and patterned output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import kwsc_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_WORDS = 950;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_PRINTED  = 40;

  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_BURSTY = 2;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [1:0] operation = OP_KEY;
  logic [7:0] char_in   = CH_NUL;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;

  keyword_substitution_cipher_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_out  (char_out)
  );

  // Shadow of the cipher table.
  letter_t               sub_table [ALPHA_SIZE];
  bit                    slot_valid[ALPHA_SIZE];
  logic [ALPHA_SIZE-1:0] used_mask    = '0;
  int                    slots_filled = 0;
  bit                    table_done   = 1'b0;

  logic [7:0] expected_chars[$];
  int         mismatches  = 0;
  int         words_sent  = 0;
  int         cycle_count = 0;
  int         burst_left  = 0;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Fold upper case; letter index 0..25 or -1 for anything else.
  function automatic int letter_of(logic [7:0] c);
    logic [7:0] f;
    f = (c >= UC_A && c <= UC_Z) ? c + CASE_GAP : c;
    return (f >= LC_A && f <= LC_Z) ? int'(f - LC_A) : -1;
  endfunction

  function automatic void clear_shadow();
    foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    used_mask    = '0;
    slots_filled = 0;
    table_done   = 1'b0;
  endfunction

  function automatic void append_shadow(int idx);
    if (used_mask[idx] || slots_filled >= ALPHA_SIZE) return;
    sub_table[slots_filled]  = letter_t'(idx);
    slot_valid[slots_filled] = 1'b1;
    used_mask[idx]           = 1'b1;
    slots_filled++;
  endfunction

  // Advance the shadow table by one accepted word and queue its character.
  function automatic void cipher_predict(op_t op, logic [7:0] c);
    int         idx;
    logic [7:0] res;
    bit         found;
    idx   = letter_of(c);
    found = 1'b0;
    case (op)
      OP_KEY: begin
        if (table_done) clear_shadow();
        if (idx >= 0) append_shadow(idx);
      end
      OP_END: begin
        for (int j = 0; j < ALPHA_SIZE; j++) append_shadow(j);
        table_done = 1'b1;
      end
      default: begin
        if (c == CH_SPACE) begin
          expected_chars.push_back(CH_SPACE);
        end else if (idx >= 0) begin
          if (op == OP_ENC) begin
            res = slot_valid[idx] ? LC_A + 8'(sub_table[idx]) : CH_NUL;
          end else begin
            // first filled slot holding the letter; miss gives 'a'
            res = LC_A;
            for (int j = 0; j < ALPHA_SIZE; j++) begin
              if (!found && slot_valid[j] && sub_table[j] == letter_t'(idx)) begin
                res   = LC_A + 8'(j);
                found = 1'b1;
              end
            end
          end
          expected_chars.push_back(res);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    if (mismatches < MAX_PRINTED)
      $display("cycle %0d: %s: got 0x%02h, want 0x%02h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Drive one word and hold it until accepted.
  task automatic send_word(op_t op, logic [7:0] c);
    in_valid  <= 1'b1;
    operation <= op;
    char_in   <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_predict(op, c);
    words_sent++;
  endtask

  task automatic hold_off(int cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Burst pacing: random-length bursts, sometimes with no gap between them.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
  endtask

  task automatic wait_drained(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    c = LC_A + 8'($urandom_range(0, ALPHA_SIZE - 1));
    if ($urandom_range(0, 1) == 1) c = c - CASE_GAP;
    return c;
  endfunction

  // Output stall pattern: phases of no stall, light random stall, long runs.
  int stall_mode = STALL_NONE;
  int stall_left = 0;
  int run_left   = 0;
  bit run_stall  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_BURSTY);
        stall_left = $urandom_range(32, 200);
      end
      stall_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            run_stall = !run_stall;
            run_left  = $urandom_range(1, 8);
          end
          run_left--;
          out_stall <= run_stall;
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_out
    logic [7:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("word with nothing expected", char_out, CH_NUL);
      end else begin
        want = expected_chars.pop_front();
        if (char_out !== want) report_mismatch("char_out", char_out, want);
      end
    end
  end

  // Lookups on an empty table: unfilled encrypt gives 0, decrypt miss gives 'a'.
  task automatic test_blank_table();
    send_word(OP_ENC, LC_A);
    send_word(OP_ENC, UC_Z);
    send_word(OP_DEC, LC_Z);
    send_word(OP_ENC, CH_SPACE);
    send_word(OP_DEC, CH_SPACE);
    send_word(OP_ENC, 8'h00);
    send_word(OP_DEC, 8'hFF);
  endtask

  // Partial key with folding, duplicates and skipped non-letters.
  task automatic test_partial_key();
    send_word(OP_KEY, 8'h4B);  // K
    send_word(OP_KEY, 8'h77);  // w
    send_word(OP_KEY, 8'h60);
    send_word(OP_KEY, 8'h6B);  // k again
    send_word(OP_KEY, UC_Z);
    send_word(OP_KEY, 8'h7B);
    send_word(OP_ENC, UC_A);
    send_word(OP_ENC, 8'h65);  // unfilled slot
    send_word(OP_DEC, 8'h57);  // W
    send_word(OP_DEC, 8'h71);  // miss
    send_word(OP_ENC, 8'h5B);
  endtask

  // Key end fills the rest; a second key end changes nothing.
  task automatic test_key_end();
    send_word(OP_END, 8'hFF);
    send_word(OP_ENC, LC_Z);
    send_word(OP_DEC, LC_A);
    send_word(OP_END, 8'h00);
    send_word(OP_ENC, 8'h59);
  endtask

  // A key word after a complete table starts a fresh one, even a non-letter.
  task automatic test_fresh_key();
    send_word(OP_KEY, 8'h80);
    send_word(OP_ENC, LC_A);
    send_word(OP_KEY, 8'h6D);
    send_word(OP_ENC, LC_A);
  endtask

  task automatic test_random_sessions();
    int start;
    int n;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any operation, any byte
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          pace();
        end
      end else begin
        n = $urandom_range(1, 14);
        repeat (n) begin
          send_word(OP_KEY, ($urandom_range(0, 4) != 0) ? any_letter()
                                                         : 8'($urandom_range(0, 255)));
          pace();
        end
        if ($urandom_range(0, 6) != 0) begin
          send_word(OP_END, 8'($urandom_range(0, 255)));
          pace();
        end
        n = $urandom_range(4, 30);
        repeat (n) begin
          case ($urandom_range(0, 19))
            0, 1, 2:    send_word($urandom_range(0, 1) ? OP_ENC : OP_DEC, CH_SPACE);
            3, 4, 5:    send_word($urandom_range(0, 1) ? OP_ENC : OP_DEC,
                                  8'($urandom_range(0, 255)));
            default:    send_word($urandom_range(0, 1) ? OP_ENC : OP_DEC, any_letter());
          endcase
          pace();
        end
      end
      if ($urandom_range(0, 11) == 0) wait_drained(0);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_blank_table();
    test_partial_key();
    test_key_end();
    test_fresh_key();
    // hold the input until every lookup so far has come back
    wait_drained(0);
    test_random_sessions();
    wait_drained(SETTLE);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
